// ===== design/swdc_pkg.sv =====
// ----------------------------------------------------------------------------
// Swipe direction classifier package
// Gesture codes, command codes, register indexes and fixed widths shared by
// the classifier datapath and the top level.
// ----------------------------------------------------------------------------
package swdc_pkg;

    typedef enum logic [2:0] {
        GEST_NONE   = 3'd0,
        GEST_LEFT   = 3'd1,
        GEST_MIDDLE = 3'd2,
        GEST_RIGHT  = 3'd3,
        GEST_TAP    = 3'd4
    } gesture_t;

    typedef enum logic {
        CMD_POLL  = 1'b0,
        CMD_CLEAR = 1'b1
    } command_t;

    // Configuration register indexes.
    localparam logic REG_SLIDE_THRESHOLD = 1'b0;
    localparam logic REG_MIDDLE_TANGENT  = 1'b1;

    localparam int CFG_W      = 12;
    localparam int THR_SQ_W   = 2 * CFG_W;
    localparam int THR_DIV5_W = 10;

    localparam logic [CFG_W-1:0] SLIDE_THRESHOLD_RST = 12'd100;
    localparam logic [CFG_W-1:0] MIDDLE_TANGENT_RST  = 12'd256;

    // threshold / 5 equals (threshold * 3277) >> 14 for every 12-bit threshold.
    localparam logic [CFG_W-1:0] DIV5_RECIP = 12'd3277;
    localparam int               DIV5_SHIFT = 14;

    localparam logic [THR_SQ_W-1:0]   THR_SQ_RST   = 24'd10000;
    localparam logic [THR_DIV5_W-1:0] THR_DIV5_RST = 10'd20;

    // Next-state decisions that the datapath hands back to the top level.
    typedef struct packed {
        logic     armed;
        gesture_t gesture;
    } swdc_result_t;

endpackage

// ===== design/swdc_classify.sv =====
// ----------------------------------------------------------------------------
// Swipe direction classifier datapath
// Travel test, direction decision, down override, tap detection and clear for one
// request, from the current poll and the held gesture state.
// ----------------------------------------------------------------------------
module swdc_classify
    import swdc_pkg::*;
#(
    parameter int COORD_WIDTH = 12
)
(
    input  logic                   command,
    input  logic                   press,
    input  logic                   lift,
    input  logic [COORD_WIDTH-1:0] pos_x,
    input  logic [COORD_WIDTH-1:0] pos_y,
    input  logic [COORD_WIDTH-1:0] start_x,
    input  logic [COORD_WIDTH-1:0] start_y,
    input  logic                   armed,
    input  gesture_t               last_gesture,
    input  logic [THR_SQ_W-1:0]    thr_sq,
    input  logic [THR_DIV5_W-1:0]  thr_div5,
    input  logic [CFG_W-1:0]       middle_tangent,
    output swdc_result_t           result
);

    localparam int W       = COORD_WIDTH;
    localparam int DIST_W  = 2 * W + 1;
    localparam int CMP_W   = (DIST_W > THR_SQ_W) ? DIST_W : THR_SQ_W;
    localparam int CROSS_W = W + CFG_W;
    localparam int DOWN_W  = (W > THR_DIV5_W) ? W : THR_DIV5_W;

    logic [W-1:0]       ref_x;
    logic [W-1:0]       ref_y;
    logic [W:0]         dx;
    logic [W:0]         dy;
    logic [W:0]         dx_mag;
    logic [W:0]         dy_mag;
    logic               dx_neg;
    logic               dy_neg;
    logic [W-1:0]       ax;
    logic [W-1:0]       ay;
    logic [2*W-1:0]     ax_sq;
    logic [2*W-1:0]     ay_sq;
    logic [DIST_W-1:0]  dist2;
    logic [CROSS_W-1:0] cross_lhs;
    logic [CROSS_W-1:0] cross_rhs;
    logic               in_cone;
    logic               down_far;
    logic               armed_now;
    logic               swipe;
    gesture_t           base_gesture;
    gesture_t           dir_gesture;

    // A touch-down in this poll moves the start point to the current one.
    assign ref_x = press ? pos_x : start_x;
    assign ref_y = press ? pos_y : start_y;

    assign dx     = {1'b0, pos_x} - {1'b0, ref_x};
    assign dy     = {1'b0, pos_y} - {1'b0, ref_y};
    assign dx_neg = dx[W];
    assign dy_neg = dy[W];
    assign dx_mag = dx_neg ? (~dx + 1'b1) : dx;
    assign dy_mag = dy_neg ? (~dy + 1'b1) : dy;
    assign ax     = dx_mag[W-1:0];
    assign ay     = dy_mag[W-1:0];

    assign ax_sq = (2*W)'(ax) * (2*W)'(ax);
    assign ay_sq = (2*W)'(ay) * (2*W)'(ay);
    assign dist2 = DIST_W'(ax_sq) + DIST_W'(ay_sq);

    // |dx| * 1.0 <= tan * |dy| with tan in Q4.8.
    assign cross_lhs = CROSS_W'({ax, 8'h00});
    assign cross_rhs = CROSS_W'(middle_tangent) * CROSS_W'(ay);
    assign in_cone   = cross_lhs <= cross_rhs;

    assign down_far = !dy_neg && (DOWN_W'(ay) > DOWN_W'(thr_div5));

    assign armed_now    = armed || press;
    assign base_gesture = press ? GEST_NONE : last_gesture;
    assign swipe        = armed_now && (CMP_W'(dist2) >= CMP_W'(thr_sq));

    always_comb
    begin
        if (!dy_neg)
        begin
            dir_gesture = (!dx_neg && (ax != '0)) ? GEST_RIGHT : GEST_LEFT;
        end
        else if (in_cone)
        begin
            dir_gesture = GEST_MIDDLE;
        end
        else
        begin
            dir_gesture = dx_neg ? GEST_LEFT : GEST_RIGHT;
        end
    end

    always_comb
    begin
        result.armed   = armed;
        result.gesture = last_gesture;
        if (command == CMD_CLEAR)
        begin
            result.gesture = GEST_NONE;
        end
        else
        begin
            result.armed   = armed_now;
            result.gesture = base_gesture;
            if (swipe)
            begin
                result.armed   = 1'b0;
                result.gesture = down_far ? GEST_NONE : dir_gesture;
            end
            else if (armed_now && lift)
            begin
                result.armed   = 1'b0;
                result.gesture = GEST_TAP;
            end
        end
    end

endmodule

// ===== design/swipe_direction_classifier.sv =====
// ----------------------------------------------------------------------------
// Swipe direction classifier
// Turns a stream of touch polls into none, left, middle, right or tap.
// ----------------------------------------------------------------------------
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------
//   input    | in_valid / in_ready  | command, press, lift, pos_x, pos_y
//   output   | out_valid / out_ready| gesture
//   config   | cfg_we               | cfg_index, cfg_data
//
// One request per cycle while in_ready is high: each request is classified in
// the cycle it is accepted and its gesture is registered in a free buffer entry.
// The path is set by the travel squares and the tangent cross product.
// A two-entry output buffer keeps input flowing while one result is stalled;
// in_ready drops only when both entries are full.
// Reset clears the gesture state and loads threshold 100 and tangent 1.0.
//
module swipe_direction_classifier
    import swdc_pkg::*;
#(
    parameter int COORD_WIDTH = 12
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   command,
    input  logic                   press,
    input  logic                   lift,
    input  logic [COORD_WIDTH-1:0] pos_x,
    input  logic [COORD_WIDTH-1:0] pos_y,

    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             gesture,

    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    logic [COORD_WIDTH-1:0] start_x_reg,  start_x_next;
    logic [COORD_WIDTH-1:0] start_y_reg,  start_y_next;
    logic                   armed_reg,    armed_next;
    gesture_t               last_gesture_reg, last_gesture_next;

    logic [THR_SQ_W-1:0]    thr_sq_reg;
    logic [THR_DIV5_W-1:0]  thr_div5_reg;
    logic [CFG_W-1:0]       tangent_reg;

    logic                   out_valid_reg,  out_valid_next;
    gesture_t               out_gesture_reg, out_gesture_next;
    logic                   skid_valid_reg, skid_valid_next;
    gesture_t               skid_gesture_reg, skid_gesture_next;

    logic                   accept;
    logic                   take_out;
    logic [THR_SQ_W-1:0]    cfg_sq;
    logic [THR_SQ_W-1:0]    cfg_div5_prod;
    swdc_result_t           result;

    assign accept   = in_valid && in_ready;
    assign in_ready = !skid_valid_reg;
    assign take_out = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign gesture   = out_gesture_reg;

    swdc_classify #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_classify (
        .command        (command),
        .press          (press),
        .lift           (lift),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .start_x        (start_x_reg),
        .start_y        (start_y_reg),
        .armed          (armed_reg),
        .last_gesture   (last_gesture_reg),
        .thr_sq         (thr_sq_reg),
        .thr_div5       (thr_div5_reg),
        .middle_tangent (tangent_reg),
        .result         (result)
    );

    // The threshold square and fifth are derived once, when it is written.
    assign cfg_sq        = THR_SQ_W'(cfg_data) * THR_SQ_W'(cfg_data);
    assign cfg_div5_prod = THR_SQ_W'(cfg_data) * THR_SQ_W'(DIV5_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_sq_reg   <= THR_SQ_RST;
            thr_div5_reg <= THR_DIV5_RST;
            tangent_reg  <= MIDDLE_TANGENT_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_SLIDE_THRESHOLD)
            begin
                thr_sq_reg   <= cfg_sq;
                thr_div5_reg <= cfg_div5_prod[DIV5_SHIFT +: THR_DIV5_W];
            end
            else
            begin
                tangent_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        start_x_next      = start_x_reg;
        start_y_next      = start_y_reg;
        armed_next        = armed_reg;
        last_gesture_next = last_gesture_reg;
        if (accept)
        begin
            if (command == CMD_POLL && press)
            begin
                start_x_next = pos_x;
                start_y_next = pos_y;
            end
            armed_next        = result.armed;
            last_gesture_next = result.gesture;
        end
    end

    always_comb
    begin
        out_valid_next    = out_valid_reg;
        out_gesture_next  = out_gesture_reg;
        skid_valid_next   = skid_valid_reg;
        skid_gesture_next = skid_gesture_reg;
        if (take_out)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next   = 1'b1;
                out_gesture_next = skid_gesture_reg;
                skid_valid_next  = 1'b0;
            end
            else
            begin
                out_valid_next   = accept;
                out_gesture_next = result.gesture;
            end
        end
        else if (accept)
        begin
            skid_valid_next   = 1'b1;
            skid_gesture_next = result.gesture;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg      <= '0;
            start_y_reg      <= '0;
            armed_reg        <= 1'b0;
            last_gesture_reg <= GEST_NONE;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            start_x_reg      <= start_x_next;
            start_y_reg      <= start_y_next;
            armed_reg        <= armed_next;
            last_gesture_reg <= last_gesture_next;
            out_valid_reg    <= out_valid_next;
            skid_valid_reg   <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_gesture_reg  <= out_gesture_next;
        skid_gesture_reg <= skid_gesture_next;
    end

    // The second buffer entry is only ever filled behind a held result.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result while the output is empty");

    // A held swipe or tap always means the gesture has ended.
    assert property (@(posedge clk) disable iff (!rst_n)
        (last_gesture_reg != GEST_NONE) |-> !armed_reg)
        else $error("gesture classified while still armed");

    // A clear request resets the result and leaves the armed flag alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command == CMD_CLEAR)
            |=> (last_gesture_reg == GEST_NONE) && (armed_reg == $past(armed_reg)))
        else $error("clear request mishandled");

    // Every accepted request shows up in one of the two buffer entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (out_valid_reg || skid_valid_reg))
        else $error("accepted request produced no result");

endmodule
